// ===== rtl/pdpr_pkg.sv =====
// Shared types and constants for the pulse-distance packet receiver.
`default_nettype none

package pdpr_pkg;

  localparam int unsigned WinW  = 8;   // width of a gap window bound
  localparam int unsigned TickW = 10;  // width of the slow-tick counter and its limits
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned MeasW = 40;  // width of the reported measurement
  localparam int unsigned OutDataW = 48;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartLow   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgStartHigh  = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgOneLow     = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgOneHigh    = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgZeroLow    = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgZeroHigh   = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgWindowTicks = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgBlinkTicks  = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [WinW-1:0]  RstStartLow    = 8'd67;
  localparam logic [WinW-1:0]  RstStartHigh   = 8'd72;
  localparam logic [WinW-1:0]  RstOneLow      = 8'd35;
  localparam logic [WinW-1:0]  RstOneHigh     = 8'd42;
  localparam logic [WinW-1:0]  RstZeroLow     = 8'd17;
  localparam logic [WinW-1:0]  RstZeroHigh    = 8'd24;
  localparam logic [TickW-1:0] RstWindowTicks = 10'd171;
  localparam logic [TickW-1:0] RstBlinkTicks  = 10'd122;

  // Item kinds carried in the input tuser.
  localparam logic KindEdge = 1'b0;
  localparam logic KindTick = 1'b1;

  // Gap windows handed to the framing logic.
  typedef struct packed {
    logic [WinW-1:0] start_low;
    logic [WinW-1:0] start_high;
    logic [WinW-1:0] one_low;
    logic [WinW-1:0] one_high;
    logic [WinW-1:0] zero_low;
    logic [WinW-1:0] zero_high;
  } pdpr_win_t;

  // Confirmation sequencer phases.
  typedef enum logic [4:0] {
    PH_WAIT_FIRST  = 5'b00001,
    PH_FIRST_DONE  = 5'b00010,
    PH_WAIT_SECOND = 5'b00100,
    PH_SECOND_DONE = 5'b01000,
    PH_BLINK       = 5'b10000
  } pdpr_phase_e;

endpackage

`default_nettype wire

// ===== rtl/pdpr_frame.sv =====
// Edge framing: start-gap detection and MSB-first bit assembly.
`default_nettype none

module pdpr_frame import pdpr_pkg::*; #(
  parameter int unsigned PACKET_BITS = 40
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   edge_en_i,   // an edge item is accepted
  input  wire logic [WinW-1:0]        interval_i,
  input  wire pdpr_win_t              win_i,
  output logic [PACKET_BITS-1:0]      rx_d_o,      // packet bits after this edge
  output logic                        done_o       // this edge completes a packet
);

  localparam int unsigned BpW  = $clog2(PACKET_BITS + 1);
  localparam int unsigned IdxW = $clog2(PACKET_BITS);
  localparam logic [BpW-1:0]  BpFull  = BpW'(PACKET_BITS);
  localparam logic [IdxW-1:0] IdxTop  = IdxW'(PACKET_BITS - 1);

  logic [BpW-1:0]         bp_q, bp_d;
  logic                   start_q, start_d;
  logic [PACKET_BITS-1:0] rx_q, rx_d;
  logic                   in_start, in_one, in_zero, room;
  logic [IdxW-1:0]        idx;

  assign in_start = (interval_i > win_i.start_low) && (interval_i < win_i.start_high);
  assign in_one   = (interval_i > win_i.one_low)   && (interval_i < win_i.one_high);
  assign in_zero  = (interval_i > win_i.zero_low)  && (interval_i < win_i.zero_high);
  assign room     = start_q && (bp_q < BpFull);
  assign idx      = IdxTop - bp_q[IdxW-1:0];

  always_comb begin
    bp_d    = bp_q;
    start_d = start_q;
    rx_d    = rx_q;
    priority if ((bp_q == '0) && in_start) begin
      start_d = 1'b1;
    end else if (room && in_one) begin
      rx_d[idx] = 1'b1;
      bp_d      = bp_q + 1'b1;
    end else if (room && in_zero) begin
      rx_d[idx] = 1'b0;
      bp_d      = bp_q + 1'b1;
    end else begin
      // any other gap drops the framing; the bits stay as they are
      start_d = 1'b0;
      bp_d    = '0;
    end
  end

  assign rx_d_o = rx_d;
  assign done_o = (bp_d == BpFull);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q    <= '0;
      start_q <= 1'b0;
      rx_q    <= '0;
    end else if (edge_en_i) begin
      bp_q    <= bp_d;
      start_q <= start_d;
      rx_q    <= rx_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pulse_distance_packet_receiver.sv =====
// Top level of the pulse-distance packet receiver: config, sequencer, output buffer.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid/tready              tdata[7:0] interval, tuser mode
//  m_axis    out  tvalid/tready              tdata[39:0] measurement, [40] valid,
//                                            [41] indicator, [42] packet_done
//  cfg       in   cfg_we_i                   cfg_idx_i, cfg_data_i
//
//  One item per cycle while tready is high: framing and sequencer update in the
//  accepting cycle and the result is registered into the output register or skid.
//  A two-entry output buffer (output register plus skid) keeps intake open while
//  one result waits; tready drops only when both entries are full.
//  rst_ni clears all but out/skid data asynchronously; config regs take defaults.
`default_nettype none

module pulse_distance_packet_receiver import pdpr_pkg::*; #(
  parameter int unsigned PACKET_BITS = 40,   // 8..64
  parameter int unsigned TICK_LIMIT  = 1000  // 1..1000, slow-tick saturation
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input items
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] interval
  input  wire logic                s_axis_tuser,   // [0] mode (0 edge, 1 slow tick)
  // result items
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [39:0] measurement,
                                                   // [40] measurement_valid,
                                                   // [41] indicator, [42] packet_done
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [TickW-1:0] TickLimit = TickW'(TICK_LIMIT);

  // ---------------- configuration registers ----------------
  pdpr_win_t        win_q;
  logic [TickW-1:0] window_q, blink_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.start_low  <= RstStartLow;
      win_q.start_high <= RstStartHigh;
      win_q.one_low    <= RstOneLow;
      win_q.one_high   <= RstOneHigh;
      win_q.zero_low   <= RstZeroLow;
      win_q.zero_high  <= RstZeroHigh;
      window_q         <= RstWindowTicks;
      blink_lim_q      <= RstBlinkTicks;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartLow:    win_q.start_low  <= cfg_data_i[WinW-1:0];
        CfgStartHigh:   win_q.start_high <= cfg_data_i[WinW-1:0];
        CfgOneLow:      win_q.one_low    <= cfg_data_i[WinW-1:0];
        CfgOneHigh:     win_q.one_high   <= cfg_data_i[WinW-1:0];
        CfgZeroLow:     win_q.zero_low   <= cfg_data_i[WinW-1:0];
        CfgZeroHigh:    win_q.zero_high  <= cfg_data_i[WinW-1:0];
        CfgWindowTicks: window_q         <= cfg_data_i[TickW-1:0];
        CfgBlinkTicks:  blink_lim_q      <= cfg_data_i[TickW-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------- intake ----------------
  logic in_acc, edge_en, tick_en;
  logic skid_valid_q;

  assign s_axis_tready = !skid_valid_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign edge_en = in_acc && (s_axis_tuser == KindEdge);
  assign tick_en = in_acc && (s_axis_tuser == KindTick);

  // ---------------- framing ----------------
  logic [PACKET_BITS-1:0] rx_d;
  logic                   frame_done, done;

  pdpr_frame #(
    .PACKET_BITS (PACKET_BITS)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_en_i  (edge_en),
    .interval_i (s_axis_tdata),
    .win_i      (win_q),
    .rx_d_o     (rx_d),
    .done_o     (frame_done)
  );

  assign done = edge_en && frame_done;

  // ---------------- confirmation sequencer ----------------
  pdpr_phase_e            phase_q, phase_d, phase_mid;
  logic [TickW-1:0]       tick_q, tick_d;
  logic [PACKET_BITS-1:0] held_q, held_d, acc_q, acc_d;
  logic                   valid_q, valid_d, blink_q, blink_d;

  always_comb begin
    // edge that completes a packet advances the waiting phases
    phase_mid = phase_q;
    if (done) begin
      unique case (phase_q)
        PH_WAIT_FIRST:  phase_mid = PH_FIRST_DONE;
        PH_WAIT_SECOND: phase_mid = PH_SECOND_DONE;
        default: ;
      endcase
    end

    tick_d = tick_q;
    if (tick_en && (tick_q < TickLimit)) begin
      tick_d = tick_q + 1'b1;
    end

    phase_d = phase_mid;
    held_d  = held_q;
    acc_d   = acc_q;
    valid_d = valid_q;
    blink_d = blink_q;
    if (tick_d > window_q) begin
      // window over: restart; a running blink keeps the indicator on
      tick_d  = '0;
      phase_d = PH_WAIT_FIRST;
    end else begin
      unique case (phase_mid)
        PH_FIRST_DONE: begin
          held_d  = rx_d;
          phase_d = PH_WAIT_SECOND;
        end
        PH_SECOND_DONE: begin
          if (held_q == rx_d) begin
            acc_d   = held_q;
            valid_d = 1'b1;
            blink_d = 1'b1;
            phase_d = PH_BLINK;
          end else begin
            phase_d = PH_WAIT_FIRST;
          end
        end
        PH_BLINK: begin
          if (tick_d > blink_lim_q) begin
            blink_d = 1'b0;
            phase_d = PH_WAIT_FIRST;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_FIRST;
      tick_q  <= '0;
      held_q  <= '0;
      acc_q   <= '0;
      valid_q <= 1'b0;
      blink_q <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      held_q  <= held_d;
      acc_q   <= acc_d;
      valid_q <= valid_d;
      blink_q <= blink_d;
    end
  end

  // ---------------- result formatting ----------------
  logic [63:0]          acc_ext;
  logic [OutDataW-1:0]  res;

  assign acc_ext = 64'(acc_d);
  assign res = {5'b0, done, blink_d, valid_d, acc_ext[MeasW-1:0]};

  // ---------------- output register plus skid ----------------
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, skid_data_q;
  logic                out_take;

  assign out_take = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_q  <= skid_valid_q || in_acc;
        skid_valid_q <= 1'b0;
      end else if (in_acc) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= out_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_data_q <= skid_valid_q ? skid_data_q : res;
    end else if (in_acc) begin
      if (out_valid_q) begin
        skid_data_q <= res;
      end else begin
        out_data_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("sequencer phase not one-hot");

  a_blink_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BLINK) |-> blink_q)
    else $error("blink phase without indicator");

  a_blink_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q |-> valid_q)
    else $error("indicator on before any accepted packet");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("skid entry lost while output stalled");
`endif

endmodule

`default_nettype wire
